@@ rtl/m4s_pkg.sv @@
// Package: action codes, controller states, command/status structs, float constants.
`default_nettype none
package m4s_pkg;

  localparam int ELEMS = 16;
  localparam int DIM   = 4;

  localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
  localparam logic [31:0] FP_QNAN = 32'hFFC0_0000;
  localparam logic [31:0] FP_QBIT = 32'h0040_0000;

  typedef enum logic [2:0] {
    ACT_NEW_ZERO  = 3'd0,
    ACT_NEW_IDENT = 3'd1,
    ACT_GET       = 3'd2,
    ACT_SET       = 3'd3,
    ACT_MUL       = 3'd4,
    ACT_EQUAL     = 3'd5,
    ACT_CLEAR     = 3'd6
  } act_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_FILL,
    ST_GET_RD,
    ST_MUL_RD,
    ST_MUL_MUL,
    ST_MUL_MWAIT,
    ST_MUL_ADD,
    ST_MUL_AWAIT,
    ST_MUL_WR,
    ST_EQ_RD,
    ST_EQ_CMP,
    ST_RESP
  } state_e;

  typedef enum logic [1:0] {
    RS_NONE,
    RS_HANDLE,
    RS_READ,
    RS_EQUAL
  } rsel_e;

  typedef enum logic [1:0] {
    WS_SET,
    WS_FILL,
    WS_PROD
  } wsel_e;

  typedef enum logic {
    FOP_MUL,
    FOP_ADD
  } fop_e;

  typedef struct packed {
    logic  capture;
    logic  idx_clr;
    logic  idx_inc;
    logic  k_inc;
    logic  mem_we;
    wsel_e wsel;
    logic  fpu_start;
    fop_e  fop;
    logic  cap_prod;
    logic  cap_sum;
    logic  sum_clr;
    logic  eq_set;
    logic  eq_step;
    logic  cnt_inc;
    logic  cnt_clr;
    logic  out_load;
    rsel_e rsel;
  } cmd_t;

  typedef struct packed {
    act_e act;
    logic a_ok;
    logic b_ok;
    logic rc_ok;
    logic full;
    logic idx_last;
    logic k_last;
    logic fpu_done;
    logic out_free;
  } sts_t;

  // Float equality: NaN never equal, +0 equals -0.
  function automatic logic fp_equal(input logic [31:0] x, input logic [31:0] y);
    logic nan_x;
    logic nan_y;
    nan_x = (x[30:23] == 8'hFF) && (x[22:0] != '0);
    nan_y = (y[30:23] == 8'hFF) && (y[22:0] != '0);
    return !nan_x && !nan_y && ((x == y) || ((x[30:0] == '0) && (y[30:0] == '0)));
  endfunction

endpackage
`default_nettype wire

@@ rtl/m4s_if.sv @@
// Interfaces: request and response channels with valid/ready.
`default_nettype none
interface m4s_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [7:0]  handle_a;
  logic [7:0]  handle_b;
  logic [2:0]  row_index;
  logic [2:0]  col_index;
  logic [31:0] write_value;

  modport source (output valid, action, handle_a, handle_b, row_index, col_index,
                  write_value, input ready);
  modport sink   (input valid, action, handle_a, handle_b, row_index, col_index,
                  write_value, output ready);
endinterface

interface m4s_rsp_if;
  logic        valid;
  logic        ready;
  logic [6:0]  result_handle;
  logic [31:0] read_value;
  logic        is_equal;

  modport source (output valid, result_handle, read_value, is_equal, input ready);
  modport sink   (input valid, result_handle, read_value, is_equal, output ready);
endinterface
`default_nettype wire

@@ rtl/m4s_fpu.sv @@
// Float32 multiply/add unit: three-stage pipeline, round to nearest even.
`default_nettype none
module m4s_fpu
  import m4s_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  fop_e             op_i,
  input  wire logic [31:0] a_i,
  input  wire logic [31:0] b_i,
  output logic      [31:0] res_o,
  output logic             done_o
);

  function automatic logic [5:0] lzc48(input logic [47:0] w);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (w[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // ---------------- stage 1: specials, product or aligned sum
  logic        sa, sb;
  logic [7:0]  ea, eb, eae, ebe;
  logic [22:0] fa, fb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [23:0] ma, mb;
  logic        spec_d;
  logic [31:0] spec_val_d;
  logic [47:0] w_d;
  logic signed [11:0] e0_d;
  logic        sign_d, zsign_d;
  logic        a_big;
  logic [23:0] ml, ms;
  logic [7:0]  el, es, dexp;
  logic [4:0]  dcl;
  logic [53:0] ext_al;
  logic [26:0] al;
  logic [27:0] ssum;

  always_comb begin
    {sa, ea, fa} = a_i;
    {sb, eb, fb} = b_i;
    nan_a  = (ea == 8'hFF) && (fa != '0);
    nan_b  = (eb == 8'hFF) && (fb != '0);
    inf_a  = (ea == 8'hFF) && (fa == '0);
    inf_b  = (eb == 8'hFF) && (fb == '0);
    zero_a = (ea == '0) && (fa == '0);
    zero_b = (eb == '0) && (fb == '0);
    ma  = {ea != '0, fa};
    mb  = {eb != '0, fb};
    eae = (ea == '0) ? 8'd1 : ea;
    ebe = (eb == '0) ? 8'd1 : eb;

    a_big  = {ea, fa} >= {eb, fb};
    ml     = a_big ? ma : mb;
    ms     = a_big ? mb : ma;
    el     = a_big ? eae : ebe;
    es     = a_big ? ebe : eae;
    dexp   = el - es;
    dcl    = (dexp > 8'd27) ? 5'd27 : dexp[4:0];
    ext_al = {ms, 3'b000, 27'b0} >> dcl;
    al     = ext_al[53:27] | {26'b0, |ext_al[26:0]};
    ssum   = (sa == sb) ? ({1'b0, ml, 3'b000} + {1'b0, al})
                        : ({1'b0, ml, 3'b000} - {1'b0, al});

    spec_d     = 1'b0;
    spec_val_d = '0;
    if (nan_a) begin
      spec_d = 1'b1; spec_val_d = a_i | FP_QBIT;
    end else if (nan_b) begin
      spec_d = 1'b1; spec_val_d = b_i | FP_QBIT;
    end else if (op_i == FOP_MUL) begin
      if (inf_a || inf_b) begin
        spec_d     = 1'b1;
        spec_val_d = (zero_a || zero_b) ? FP_QNAN : {sa ^ sb, 8'hFF, 23'b0};
      end
    end else begin
      if (inf_a && inf_b && (sa != sb)) begin
        spec_d = 1'b1; spec_val_d = FP_QNAN;
      end else if (inf_a) begin
        spec_d = 1'b1; spec_val_d = a_i;
      end else if (inf_b) begin
        spec_d = 1'b1; spec_val_d = b_i;
      end
    end

    if (op_i == FOP_MUL) begin
      w_d     = ma * mb;
      e0_d    = $signed({4'b0, eae}) + $signed({4'b0, ebe}) - 12'sd126;
      sign_d  = sa ^ sb;
      zsign_d = sa ^ sb;
    end else begin
      w_d     = {ssum, 20'b0};
      e0_d    = $signed({4'b0, el}) + 12'sd1;
      sign_d  = a_big ? sa : sb;
      zsign_d = sa & sb;
    end
  end

  logic [2:0]  v_q;
  logic        spec1_q, spec2_q;
  logic [31:0] specv1_q, specv2_q;
  logic [47:0] w1_q, w2_q;
  logic signed [11:0] e01_q, e02_q;
  logic        sign1_q, sign2_q, zs1_q, zs2_q;
  logic [5:0]  lz2_q;
  logic [31:0] res_q, res_d;

  // valid pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], start_i};
    end
  end

  // stage registers
  always_ff @(posedge clk_i) begin
    spec1_q  <= spec_d;
    specv1_q <= spec_val_d;
    w1_q     <= w_d;
    e01_q    <= e0_d;
    sign1_q  <= sign_d;
    zs1_q    <= zsign_d;
    // stage 2: leading zero count
    spec2_q  <= spec1_q;
    specv2_q <= specv1_q;
    w2_q     <= w1_q;
    e02_q    <= e01_q;
    sign2_q  <= sign1_q;
    zs2_q    <= zs1_q;
    lz2_q    <= lzc48(w1_q);
    // stage 3: normalize, round, pack
    res_q    <= res_d;
  end

  logic signed [11:0] en;
  logic [47:0] x;
  logic [9:0]  expm1;
  logic [6:0]  rsh;
  logic [95:0] ext_r;
  logic [23:0] m24;
  logic        rnd_up;
  logic [24:0] m25;
  logic [33:0] tot;

  always_comb begin
    en     = e02_q - $signed({6'b0, lz2_q});
    x      = '0;
    expm1  = '0;
    rsh    = '0;
    ext_r  = '0;
    if (en >= 12'sd1) begin
      x     = w2_q << lz2_q;
      expm1 = 10'(en - 12'sd1);
    end else if (e02_q >= 12'sd1) begin
      x     = w2_q << 6'(e02_q - 12'sd1);
    end else begin
      rsh   = (e02_q < -12'sd49) ? 7'd50 : 7'(12'sd1 - e02_q);
      ext_r = {w2_q, 48'b0} >> rsh;
      x     = ext_r[95:48] | {47'b0, |ext_r[47:0]};
    end
    m24    = x[47:24];
    rnd_up = x[23] & ((|x[22:0]) | m24[0]);
    m25    = {1'b0, m24} + {24'b0, rnd_up};
    tot    = {1'b0, expm1, 23'b0} + {9'b0, m25};

    if (spec2_q) begin
      res_d = specv2_q;
    end else if (w2_q == '0) begin
      res_d = {zs2_q, 31'b0};
    end else if (tot >= 34'h0_7F80_0000) begin
      res_d = {sign2_q, 8'hFF, 23'b0};
    end else begin
      res_d = {sign2_q, tot[30:0]};
    end
  end

  assign res_o  = res_q;
  assign done_o = v_q[2];

endmodule
`default_nettype wire

@@ rtl/m4s_datapath.sv @@
// Datapath: input word register, matrix memory, counters, float unit, output register.
`default_nettype none
module m4s_datapath
  import m4s_pkg::*;
#(
  parameter int MAX_MATS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [2:0]  action_i,
  input  wire logic [7:0]  handle_a_i,
  input  wire logic [7:0]  handle_b_i,
  input  wire logic [2:0]  row_index_i,
  input  wire logic [2:0]  col_index_i,
  input  wire logic [31:0] write_value_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic      [6:0]  result_handle_o,
  output logic      [31:0] read_value_o,
  output logic             is_equal_o
);

  localparam int HW    = (MAX_MATS > 1) ? $clog2(MAX_MATS) : 1;
  localparam int AW    = HW + 4;
  localparam int DEPTH = MAX_MATS * ELEMS;
  localparam int CW    = $clog2(MAX_MATS + 1);
  localparam int CMPW  = (CW > 8) ? CW : 8;

  // captured input word
  act_e        act_q;
  logic [7:0]  ha_q, hb_q;
  logic [2:0]  row_q, col_q;
  logic [31:0] val_q;

  // memory read data and accumulator registers
  logic [31:0] mem_q [DEPTH];
  logic [31:0] rda_q, rdb_q;
  logic [31:0] sum_q, prod_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q <= act_e'(action_i);
      ha_q  <= handle_a_i;
      hb_q  <= handle_b_i;
      row_q <= row_index_i;
      col_q <= col_index_i;
      val_q <= write_value_i;
    end
  end

  // control counters
  logic [CW-1:0] count_q;
  logic [3:0]    idx_q;
  logic [1:0]    k_q;
  logic          eq_q;
  logic          out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      k_q         <= '0;
      eq_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.cnt_clr)      count_q <= '0;
      else if (cmd_i.cnt_inc) count_q <= count_q + CW'(1);
      if (cmd_i.idx_clr)      idx_q <= '0;
      else if (cmd_i.idx_inc) idx_q <= idx_q + 4'd1;
      if (cmd_i.idx_clr)      k_q <= '0;
      else if (cmd_i.k_inc)   k_q <= k_q + 2'd1;
      if (cmd_i.eq_set)       eq_q <= 1'b1;
      else if (cmd_i.eq_step) eq_q <= eq_q & fp_equal(rda_q, rdb_q);
      if (cmd_i.out_load)     out_valid_q <= 1'b1;
      else if (out_ready_i)   out_valid_q <= 1'b0;
    end
  end

  // handle checks and slot numbers
  logic          a_ok, b_ok;
  logic [HW-1:0] slot_a, slot_b, slot_n;

  assign a_ok   = (ha_q != 8'd0) && (CMPW'(ha_q) <= CMPW'(count_q));
  assign b_ok   = (hb_q != 8'd0) && (CMPW'(hb_q) <= CMPW'(count_q));
  assign slot_a = HW'(ha_q - 8'd1);
  assign slot_b = HW'(hb_q - 8'd1);
  assign slot_n = HW'(count_q);

  // memory addresses
  logic [3:0]    low_a, low_b;
  logic [AW-1:0] raddr_a, raddr_b, waddr;
  logic [31:0]   wdata;

  always_comb begin
    case (act_q)
      ACT_GET: low_a = {row_q[1:0], col_q[1:0]};
      ACT_MUL: low_a = {idx_q[3:2], k_q};
      default: low_a = idx_q;
    endcase
    low_b   = (act_q == ACT_MUL) ? {k_q, idx_q[1:0]} : idx_q;
    raddr_a = {slot_a, low_a};
    raddr_b = {slot_b, low_b};
    case (cmd_i.wsel)
      WS_SET: begin
        waddr = {slot_a, row_q[1:0], col_q[1:0]};
        wdata = val_q;
      end
      WS_FILL: begin
        waddr = {slot_n, idx_q};
        wdata = ((act_q == ACT_NEW_IDENT) && (idx_q[3:2] == idx_q[1:0])) ? FP_ONE : '0;
      end
      default: begin
        waddr = {slot_n, idx_q};
        wdata = sum_q;
      end
    endcase
  end

  // matrix store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_we) mem_q[waddr] <= wdata;
    rda_q <= mem_q[raddr_a];
    rdb_q <= mem_q[raddr_b];
  end

  // float unit and its operand/result registers
  logic [31:0] fpu_a, fpu_b, fpu_res;
  logic        fpu_done;

  assign fpu_a = (cmd_i.fop == FOP_MUL) ? rda_q : sum_q;
  assign fpu_b = (cmd_i.fop == FOP_MUL) ? rdb_q : prod_q;

  m4s_fpu u_fpu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.fpu_start),
    .op_i    (cmd_i.fop),
    .a_i     (fpu_a),
    .b_i     (fpu_b),
    .res_o   (fpu_res),
    .done_o  (fpu_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_prod) prod_q <= fpu_res;
    if (cmd_i.sum_clr)      sum_q <= '0;
    else if (cmd_i.cap_sum) sum_q <= fpu_res;
  end

  // result word register
  logic [6:0]  rh_q;
  logic [31:0] rv_q;
  logic        eqo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rh_q  <= (cmd_i.rsel == RS_HANDLE) ? 7'(count_q) : 7'd0;
      rv_q  <= (cmd_i.rsel == RS_READ) ? rda_q : 32'd0;
      eqo_q <= (cmd_i.rsel == RS_EQUAL) ? eq_q : 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_handle_o = rh_q;
  assign read_value_o    = rv_q;
  assign is_equal_o      = eqo_q;

  // status to controller
  assign sts_o.act      = act_q;
  assign sts_o.a_ok     = a_ok;
  assign sts_o.b_ok     = b_ok;
  assign sts_o.rc_ok    = !row_q[2] && !col_q[2];
  assign sts_o.full     = (count_q == CW'(MAX_MATS));
  assign sts_o.idx_last = (idx_q == 4'(ELEMS - 1));
  assign sts_o.k_last   = (k_q == 2'(DIM - 1));
  assign sts_o.fpu_done = fpu_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule
`default_nettype wire

@@ rtl/m4s_ctrl.sv @@
// Controller: state machine sequencing allocation, access, multiply and compare.
`default_nettype none
module m4s_ctrl
  import m4s_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  sts_t      sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  rsel_e  rsel_q, rsel_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rsel_q  <= RS_NONE;
    end else begin
      state_q <= state_d;
      rsel_q  <= rsel_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    rsel_d  = rsel_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DISPATCH;
      ST_DISPATCH: begin
        rsel_d  = RS_NONE;
        state_d = ST_RESP;
        unique case (sts_i.act)
          ACT_NEW_ZERO, ACT_NEW_IDENT: if (!sts_i.full) begin
            state_d = ST_FILL;
            rsel_d  = RS_HANDLE;
          end
          ACT_GET: if (sts_i.a_ok && sts_i.rc_ok) begin
            state_d = ST_GET_RD;
            rsel_d  = RS_READ;
          end
          ACT_MUL: if (sts_i.a_ok && sts_i.b_ok && !sts_i.full) begin
            state_d = ST_MUL_RD;
            rsel_d  = RS_HANDLE;
          end
          ACT_EQUAL: if (sts_i.a_ok && sts_i.b_ok) begin
            state_d = ST_EQ_RD;
            rsel_d  = RS_EQUAL;
          end
          default: state_d = ST_RESP;
        endcase
      end
      ST_FILL:      if (sts_i.idx_last) state_d = ST_RESP;
      ST_GET_RD:    state_d = ST_RESP;
      ST_MUL_RD:    state_d = ST_MUL_MUL;
      ST_MUL_MUL:   state_d = ST_MUL_MWAIT;
      ST_MUL_MWAIT: if (sts_i.fpu_done) state_d = ST_MUL_ADD;
      ST_MUL_ADD:   state_d = ST_MUL_AWAIT;
      ST_MUL_AWAIT: if (sts_i.fpu_done) state_d = sts_i.k_last ? ST_MUL_WR : ST_MUL_RD;
      ST_MUL_WR:    state_d = sts_i.idx_last ? ST_RESP : ST_MUL_RD;
      ST_EQ_RD:     state_d = ST_EQ_CMP;
      ST_EQ_CMP:    state_d = sts_i.idx_last ? ST_RESP : ST_EQ_RD;
      ST_RESP:      if (sts_i.out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.wsel = WS_SET;
    cmd_o.fop  = FOP_MUL;
    cmd_o.rsel = rsel_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_DISPATCH: begin
        cmd_o.idx_clr = 1'b1;
        cmd_o.sum_clr = 1'b1;
        cmd_o.eq_set  = 1'b1;
        unique case (sts_i.act)
          ACT_SET:   cmd_o.mem_we  = sts_i.a_ok && sts_i.rc_ok;
          ACT_CLEAR: cmd_o.cnt_clr = 1'b1;
          default:   cmd_o.mem_we  = 1'b0;
        endcase
      end
      ST_FILL: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.wsel    = WS_FILL;
        cmd_o.idx_inc = 1'b1;
        cmd_o.cnt_inc = sts_i.idx_last;
      end
      ST_MUL_MUL: cmd_o.fpu_start = 1'b1;
      ST_MUL_MWAIT: cmd_o.cap_prod = sts_i.fpu_done;
      ST_MUL_ADD: begin
        cmd_o.fpu_start = 1'b1;
        cmd_o.fop       = FOP_ADD;
      end
      ST_MUL_AWAIT: begin
        cmd_o.cap_sum = sts_i.fpu_done;
        cmd_o.k_inc   = sts_i.fpu_done;
      end
      ST_MUL_WR: begin
        cmd_o.mem_we  = 1'b1;
        cmd_o.wsel    = WS_PROD;
        cmd_o.sum_clr = 1'b1;
        cmd_o.idx_inc = 1'b1;
        cmd_o.cnt_inc = sts_i.idx_last;
      end
      ST_EQ_CMP: begin
        cmd_o.eq_step = 1'b1;
        cmd_o.idx_inc = 1'b1;
      end
      ST_RESP: cmd_o.out_load = sts_i.out_free;
      default: cmd_o.capture = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/mat4_store_multiply_engine.sv @@
// Top level: store of 4x4 float32 matrices with allocate, access, multiply and compare.
//
//  channel | dir | handshake   | word
//  req     | in  | valid/ready | action, handle_a, handle_b, row_index, col_index, write_value
//  rsp     | out | valid/ready | result_handle, read_value, is_equal
//
// One request at a time. A multiply performs 64 multiply-adds (each of them is a
// memory read, then a multiply and an add, each through the three-stage float unit).
// Reset clears the handle count and control; the matrix words are undefined until written.
// A request is taken while the previous result still waits in the output register;
// the new result is loaded into it only once the old one has been taken.
`default_nettype none
module mat4_store_multiply_engine
  import m4s_pkg::*;
#(
  parameter int MAX_MATS = 64
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  m4s_req_if.sink   req,
  m4s_rsp_if.source rsp
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  m4s_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  m4s_datapath #(
    .MAX_MATS (MAX_MATS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .action_i        (req.action),
    .handle_a_i      (req.handle_a),
    .handle_b_i      (req.handle_b),
    .row_index_i     (req.row_index),
    .col_index_i     (req.col_index),
    .write_value_i   (req.write_value),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (rsp.ready),
    .out_valid_o     (rsp.valid),
    .result_handle_o (rsp.result_handle),
    .read_value_o    (rsp.read_value),
    .is_equal_o      (rsp.is_equal)
  );

  assign req.ready = in_ready;

  // memory is written only while a request is in progress
  a_we_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mem_we |-> !in_ready) else $error("memory write while idle");

  // never allocate past the store size
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.cnt_inc |-> !sts.full) else $error("allocation with full store");

  // float unit signals done after each start
  a_fpu_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fpu_start |-> ##3 sts.fpu_done) else $error("float unit latency");

  // a result is loaded only into a free output register
  a_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free) else $error("result overwrite");

endmodule
`default_nettype wire

@@ verif/mat4_store_multiply_engine_tb.sv @@
// Testbench for the 4x4 float32 matrix store: directed and random requests vs a predictor.
`default_nettype none
module mat4_store_multiply_engine_tb;
  import m4s_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NMATS      = 64;
  localparam logic [2:0]  ACT_UNUSED = 3'd7;
  localparam logic [31:0] FP_INF     = 32'h7F80_0000;
  localparam logic [31:0] FP_NZERO   = 32'h8000_0000;

  typedef struct {
    logic [2:0]  action;
    logic [7:0]  ha;
    logic [7:0]  hb;
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] val;
  } word_t;

  typedef struct {
    logic [6:0]  handle;
    logic [31:0] rd;
    logic        eq;
  } rsp_t;

  logic clk_i;
  logic rst_ni;
  m4s_req_if req_ch ();
  m4s_rsp_if rsp_ch ();

  mat4_store_multiply_engine #(.MAX_MATS(NMATS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_ch),
    .rsp    (rsp_ch)
  );

  // Predictor state
  logic [31:0] mat_words [NMATS*16];
  int          mat_cnt;
  rsp_t        pending_q [$];
  int          errors;
  bit          calm;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ---------------- float32 arithmetic, round to nearest even ----------------
  function automatic bit is_nan(logic [31:0] x);
    return (x[30:23] == 8'hFF) && (x[22:0] != '0);
  endfunction

  // value = m * 2^ex, rounded and encoded
  function automatic logic [31:0] round_pack(logic s, int ex, logic [63:0] m);
    int n;
    int e;
    int sh;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] v;
    if (m == 0) return {s, 31'b0};
    n = 63;
    while (!m[n]) n--;
    e = ex + n + 127;
    sh = (e < 1) ? (-149 - ex) : (n - 23);
    if (sh <= 0) begin
      q = m << (-sh);
    end else if (sh > 63) begin
      q = 0;
    end else begin
      q = m >> sh;
      rem = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q++;
    end
    v = (e < 1) ? q : ((64'(e - 1) << 23) + q);
    if (v >= 64'h7F80_0000) return {s, 8'hFF, 23'b0};
    return {s, v[30:0]};
  endfunction

  function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
    logic [63:0] ma;
    logic [63:0] mb;
    int ea;
    int eb;
    logic s;
    s = a[31] ^ b[31];
    if (is_nan(a)) return a | FP_QBIT;
    if (is_nan(b)) return b | FP_QBIT;
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
      if (a[30:0] == '0 || b[30:0] == '0) return FP_QNAN;
      return {s, 8'hFF, 23'b0};
    end
    ea = (a[30:23] == 0) ? 1 : int'(a[30:23]);
    eb = (b[30:23] == 0) ? 1 : int'(b[30:23]);
    ma = {40'b0, a[30:23] != 0, a[22:0]};
    mb = {40'b0, b[30:23] != 0, b[22:0]};
    return round_pack(s, ea - 150 + eb - 150, ma * mb);
  endfunction

  function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
    logic [63:0] mbig;
    logic [63:0] msml;
    logic [63:0] mres;
    logic [31:0] big;
    logic [31:0] sml;
    int eg;
    int es;
    int d;
    logic s;
    if (is_nan(a)) return a | FP_QBIT;
    if (is_nan(b)) return b | FP_QBIT;
    if (a[30:23] == 8'hFF && b[30:23] == 8'hFF) return (a[31] == b[31]) ? a : FP_QNAN;
    if (a[30:23] == 8'hFF) return a;
    if (b[30:23] == 8'hFF) return b;
    if (a[30:0] == '0 && b[30:0] == '0) return {a[31] & b[31], 31'b0};
    if (a[30:23] >= b[30:23]) begin
      big = a; sml = b;
    end else begin
      big = b; sml = a;
    end
    eg = (big[30:23] == 0) ? 1 : int'(big[30:23]);
    es = (sml[30:23] == 0) ? 1 : int'(sml[30:23]);
    mbig = {8'b0, big[30:23] != 0, big[22:0], 32'b0};
    msml = {8'b0, sml[30:23] != 0, sml[22:0], 32'b0};
    d = eg - es;
    // lost bits fold into a sticky bit
    if (d >= 63) msml = {63'b0, msml != 0};
    else if (d > 0) msml = (msml >> d) | {63'b0, (msml & ((64'd1 << d) - 1)) != 0};
    if (big[31] == sml[31]) begin
      mres = mbig + msml;
      s = big[31];
    end else if (mbig == msml) begin
      return 32'h0;
    end else if (mbig > msml) begin
      mres = mbig - msml;
      s = big[31];
    end else begin
      mres = msml - mbig;
      s = sml[31];
    end
    return round_pack(s, eg - 182, mres);
  endfunction

  function automatic bit f_same(logic [31:0] x, logic [31:0] y);
    if (is_nan(x) || is_nan(y)) return 0;
    return (x == y) || (x[30:0] == '0 && y[30:0] == '0);
  endfunction

  // ---------------- predictor ----------------
  function automatic logic [6:0] store_alloc(bit diag);
    if (mat_cnt >= NMATS) return 0;
    for (int i = 0; i < 16; i++)
      mat_words[mat_cnt*16 + i] = (diag && (i % 5) == 0) ? FP_ONE : 32'h0;
    mat_cnt++;
    return 7'(mat_cnt);
  endfunction

  function automatic bit handle_ok(logic [7:0] h);
    return h >= 1 && int'(h) <= mat_cnt;
  endfunction

  function automatic rsp_t predict_store(word_t w);
    rsp_t r;
    int pa;
    int pb;
    int po;
    logic [31:0] acc;
    logic [6:0] h;
    r = '{handle: 0, rd: 0, eq: 0};
    pa = (int'(w.ha) - 1) * 16;
    pb = (int'(w.hb) - 1) * 16;
    case (w.action)
      ACT_NEW_ZERO:  r.handle = store_alloc(0);
      ACT_NEW_IDENT: r.handle = store_alloc(1);
      ACT_GET: if (handle_ok(w.ha) && w.row < 4 && w.col < 4)
        r.rd = mat_words[pa + w.row*4 + w.col];
      ACT_SET: if (handle_ok(w.ha) && w.row < 4 && w.col < 4)
        mat_words[pa + w.row*4 + w.col] = w.val;
      ACT_MUL: if (handle_ok(w.ha) && handle_ok(w.hb)) begin
        h = store_alloc(0);
        if (h != 0) begin
          po = (int'(h) - 1) * 16;
          for (int rr = 0; rr < 4; rr++)
            for (int cc = 0; cc < 4; cc++) begin
              acc = 32'h0;
              for (int k = 0; k < 4; k++)
                acc = f_add(acc, f_mul(mat_words[pa + rr*4 + k], mat_words[pb + k*4 + cc]));
              mat_words[po + rr*4 + cc] = acc;
            end
          r.handle = h;
        end
      end
      ACT_EQUAL: if (handle_ok(w.ha) && handle_ok(w.hb)) begin
        r.eq = 1;
        for (int i = 0; i < 16; i++)
          if (!f_same(mat_words[pa + i], mat_words[pb + i])) r.eq = 0;
      end
      ACT_CLEAR: mat_cnt = 0;
      default: ;
    endcase
    return r;
  endfunction

  // ---------------- request side ----------------
  task automatic send_word(word_t w);
    if (!calm && $urandom_range(0, 7) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.action      <= w.action;
    req_ch.handle_a    <= w.ha;
    req_ch.handle_b    <= w.hb;
    req_ch.row_index   <= w.row;
    req_ch.col_index   <= w.col;
    req_ch.write_value <= w.val;
    do @(posedge clk_i); while (!req_ch.ready);
    pending_q.insert(pending_q.size(), predict_store(w));
  endtask

  task automatic send_op(logic [2:0] act, logic [7:0] ha = 0, logic [7:0] hb = 0,
                         logic [2:0] row = 0, logic [2:0] col = 0, logic [31:0] val = 0);
    word_t w;
    w = '{action: act, ha: ha, hb: hb, row: row, col: col, val: val};
    send_word(w);
  endtask

  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // ---------------- response side ----------------
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 10);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    rsp_t e;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result word handle=%0d read=%h eq=%b", $time,
                 rsp_ch.result_handle, rsp_ch.read_value, rsp_ch.is_equal);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (rsp_ch.result_handle !== e.handle) begin
          $display("%0t: result_handle expected %0d actual %0d", $time, e.handle,
                   rsp_ch.result_handle);
          errors++;
        end
        if (rsp_ch.read_value !== e.rd) begin
          $display("%0t: read_value expected %h actual %h", $time, e.rd, rsp_ch.read_value);
          errors++;
        end
        if (rsp_ch.is_equal !== e.eq) begin
          $display("%0t: is_equal expected %b actual %b", $time, e.eq, rsp_ch.is_equal);
          errors++;
        end
      end
    end
  end

  // ---------------- stimulus helpers ----------------
  function automatic logic [31:0] pick_float();
    logic [31:0] specials [8] = '{32'h0, FP_NZERO, FP_INF, 32'hFF80_0000, 32'h7FC0_0001,
                                  32'h7F80_0001, 32'h0000_0001, 32'h807F_FFFF};
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return {1'($urandom_range(0, 1)), 8'($urandom_range(120, 134)),
                             23'($urandom)};
      5: return specials[$urandom_range(0, 7)];
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [7:0] pick_handle();
    if (mat_cnt > 0 && $urandom_range(0, 99) < 85) return 8'($urandom_range(1, mat_cnt));
    return 8'($urandom_range(0, 255));
  endfunction

  // ---------------- tests ----------------
  task automatic test_alloc_and_get();
    send_op(ACT_NEW_ZERO);
    send_op(ACT_NEW_IDENT);
    send_op(ACT_GET, 2, 0, 0, 0);
    send_op(ACT_GET, 2, 0, 3, 3);
    send_op(ACT_GET, 2, 0, 1, 2);
    send_op(ACT_GET, 1, 0, 3, 3);
    send_op(ACT_GET, 2, 0, 7, 0);
    send_op(ACT_GET, 2, 0, 0, 7);
    send_op(ACT_GET, 0, 0, 0, 0);
    send_op(ACT_GET, 255, 0, 0, 0);
    send_op(ACT_GET, 3, 0, 0, 0);
  endtask

  task automatic test_set_and_multiply();
    send_op(ACT_SET, 1, 0, 0, 0, 32'h4040_0000);
    send_op(ACT_SET, 1, 0, 3, 3, 32'hFFFF_FFFF);
    send_op(ACT_SET, 1, 0, 7, 7, 32'h4000_0000);
    send_op(ACT_SET, 0, 0, 0, 0, 32'h4000_0000);
    send_op(ACT_GET, 1, 0, 3, 3);
    send_op(ACT_MUL, 1, 2);
    send_op(ACT_GET, 3, 0, 0, 0);
    send_op(ACT_MUL, 1, 0);
    send_op(ACT_MUL, 255, 2);
  endtask

  task automatic test_equal_cases();
    send_op(ACT_EQUAL, 1, 3);
    send_op(ACT_EQUAL, 2, 2);
    send_op(ACT_NEW_ZERO);
    send_op(ACT_SET, 4, 0, 2, 1, FP_NZERO);
    send_op(ACT_EQUAL, 4, 4);
    send_op(ACT_NEW_ZERO);
    send_op(ACT_EQUAL, 4, 5);
    send_op(ACT_EQUAL, 1, 1);
    send_op(ACT_EQUAL, 0, 1);
    send_op(ACT_EQUAL, 1, 200);
  endtask

  task automatic test_specials_multiply();
    send_op(ACT_NEW_IDENT);
    send_op(ACT_SET, 6, 0, 0, 1, FP_INF);
    send_op(ACT_SET, 6, 0, 1, 0, 32'h0000_0003);
    send_op(ACT_SET, 6, 0, 2, 2, 32'h7F7F_FFFF);
    send_op(ACT_MUL, 6, 6);
    send_op(ACT_MUL, 5, 6);
    send_op(ACT_EQUAL, 7, 7);
  endtask

  task automatic test_store_full();
    send_op(ACT_CLEAR);
    for (int i = 0; i < NMATS; i++) send_op(i[0] ? ACT_NEW_IDENT : ACT_NEW_ZERO);
    send_op(ACT_NEW_ZERO);
    send_op(ACT_NEW_IDENT);
    send_op(ACT_MUL, 1, 2);
    send_op(ACT_GET, 64, 0, 0, 0);
    send_op(ACT_GET, 65, 0, 0, 0);
  endtask

  task automatic test_clear_and_unused();
    send_op(ACT_UNUSED, 1, 1, 1, 1, 32'hFFFF_FFFF);
    send_op(ACT_CLEAR);
    send_op(ACT_GET, 1, 0, 0, 0);
    send_op(ACT_EQUAL, 1, 1);
    send_op(ACT_MUL, 1, 1);
    send_op(ACT_NEW_IDENT);
    send_op(ACT_GET, 1, 0, 1, 1);
  endtask

  task automatic test_random_traffic(int count);
    word_t w;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      w.ha  = pick_handle();
      w.hb  = pick_handle();
      w.row = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 3));
      w.col = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'($urandom_range(0, 3));
      w.val = pick_float();
      if (r < 6)       w.action = ACT_NEW_ZERO;
      else if (r < 12) w.action = ACT_NEW_IDENT;
      else if (r < 30) w.action = ACT_GET;
      else if (r < 55) w.action = ACT_SET;
      else if (r < 78) w.action = ACT_MUL;
      else if (r < 92) w.action = ACT_EQUAL;
      else if (r < 95) w.action = ACT_UNUSED;
      else if (r < 97 || mat_cnt == NMATS) w.action = ACT_CLEAR;
      else begin
        w.action = 3'($urandom_range(0, 7));
        w.ha = 8'($urandom);
        w.hb = 8'($urandom);
        w.row = 3'($urandom);
        w.col = 3'($urandom);
        w.val = $urandom;
      end
      // a full store mostly gets cleared, but not always
      if (mat_cnt == NMATS && w.action == ACT_CLEAR && $urandom_range(0, 3) == 0)
        w.action = ACT_MUL;
      send_word(w);
    end
  endtask

  // ---------------- sequence ----------------
  initial begin
    errors = 0;
    mat_cnt = 0;
    calm = 0;
    rst_ni = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.action = '0;
    req_ch.handle_a = '0;
    req_ch.handle_b = '0;
    req_ch.row_index = '0;
    req_ch.col_index = '0;
    req_ch.write_value = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_alloc_and_get();
    test_set_and_multiply();
    test_equal_cases();
    test_specials_multiply();
    drain_results();
    test_clear_and_unused();
    test_store_full();
    test_random_traffic(1250);
    calm = 1;
    test_random_traffic(200);
    req_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire
